>>> rtl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared counter type for the Miller-Rabin round engine.
// ----------------------------------------------------------------------------
package mrr_pkg;

    // Step and shift counters; wide enough for numbers of up to 32 bits.
    typedef logic [5:0] bit_count_t;

endpackage

>>> rtl/mrr_mulmod.sv
// ----------------------------------------------------------------------------
// mrr_mulmod
// Bit-serial modular multiplier: result = (x * m) mod n, with x < n.
// Scans m from its top bit, one bit per cycle.
// ----------------------------------------------------------------------------
module mrr_mulmod
    import mrr_pkg::*;
#(
    parameter int unsigned NUMBER_BITS = 28
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NUMBER_BITS-1:0] x,
    input  logic [NUMBER_BITS-1:0] m,
    input  logic [NUMBER_BITS-1:0] n,
    output logic                   done,
    output logic [NUMBER_BITS-1:0] result
);

    logic [NUMBER_BITS-1:0] acc_reg;
    logic [NUMBER_BITS-1:0] acc_next;
    logic [NUMBER_BITS-1:0] m_reg;
    bit_count_t             cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [NUMBER_BITS:0]   n_ext;
    logic [NUMBER_BITS:0]   dbl;
    logic [NUMBER_BITS:0]   red;
    logic [NUMBER_BITS:0]   sum;
    logic [NUMBER_BITS:0]   sum_red;

    always_comb
    begin
        n_ext    = {1'b0, n};
        dbl      = {acc_reg, 1'b0};
        red      = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
        sum      = red + {1'b0, x};
        sum_red  = (sum >= n_ext) ? (sum - n_ext) : sum;
        acc_next = m_reg[NUMBER_BITS-1] ? sum_red[NUMBER_BITS-1:0] : red[NUMBER_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            m_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                acc_reg  <= '0;
                m_reg    <= m;
                cnt_reg  <= bit_count_t'(NUMBER_BITS - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                m_reg   <= {m_reg[NUMBER_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg - bit_count_t'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

>>> rtl/miller_rabin_round_top.sv
// ----------------------------------------------------------------------------
// miller_rabin_round_top
// One Miller-Rabin round per transfer, with a composite flag kept across the
// rounds of one candidate.
// ----------------------------------------------------------------------------
// Flow: candidates below three or even go straight to the output state; otherwise n - 1
//   is split as d * 2^s, the witness is reduced mod n and raised to d, and at most s
//   closing squarings follow.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: asynchronous, active low; clears the composite flag and the output.
// ----------------------------------------------------------------------------
module miller_rabin_round_top
    import mrr_pkg::*;
#(
    parameter int unsigned NUMBER_BITS = 28
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [NUMBER_BITS-1:0] candidate,
    input  logic [NUMBER_BITS-1:0] witness,
    input  logic                   final_round,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   probably_prime,
    output logic                   verdict_final
);

    localparam logic [NUMBER_BITS-1:0] ONE = NUMBER_BITS'(1);
    localparam logic [NUMBER_BITS-1:0] TWO = NUMBER_BITS'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_RED,
        S_EXP_SQ,
        S_EXP_MUL,
        S_CHK,
        S_POST_SQ,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic [NUMBER_BITS-1:0] n_reg;
    logic [NUMBER_BITS-1:0] nm1_reg;
    logic [NUMBER_BITS-1:0] w_reg;
    logic [NUMBER_BITS-1:0] a_reg;
    logic [NUMBER_BITS-1:0] y_reg;
    logic [NUMBER_BITS-1:0] e_reg;
    bit_count_t             s_reg;
    bit_count_t             k_reg;
    bit_count_t             cnt_reg;
    logic                   fin_reg;
    logic                   comp_reg;
    logic                   seen_reg;
    logic                   mul_start_reg;
    logic [NUMBER_BITS-1:0] mul_x_reg;
    logic [NUMBER_BITS-1:0] mul_m_reg;
    logic                   out_valid_reg;
    logic                   probably_prime_reg;
    logic                   verdict_final_reg;

    logic                   mul_done;
    logic [NUMBER_BITS-1:0] mul_result;
    logic                   in_xfer;

    mrr_mulmod #(
        .NUMBER_BITS(NUMBER_BITS)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_reg),
        .x      (mul_x_reg),
        .m      (mul_m_reg),
        .n      (n_reg),
        .done   (mul_done),
        .result (mul_result)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            n_reg              <= '0;
            nm1_reg            <= '0;
            w_reg              <= '0;
            a_reg              <= '0;
            y_reg              <= '0;
            e_reg              <= '0;
            s_reg              <= '0;
            k_reg              <= '0;
            cnt_reg            <= '0;
            fin_reg            <= 1'b0;
            comp_reg           <= 1'b0;
            seen_reg           <= 1'b0;
            mul_start_reg      <= 1'b0;
            mul_x_reg          <= '0;
            mul_m_reg          <= '0;
            out_valid_reg      <= 1'b0;
            probably_prime_reg <= 1'b0;
            verdict_final_reg  <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        n_reg   <= candidate;
                        nm1_reg <= candidate - ONE;
                        e_reg   <= candidate - ONE;
                        w_reg   <= witness;
                        fin_reg <= final_round;
                        s_reg   <= '0;
                        priority if (candidate == TWO)
                        begin
                            comp_reg  <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else if (candidate[NUMBER_BITS-1:1] == '0 || !candidate[0])
                        begin
                            comp_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_SPLIT;
                        end
                    end
                end

                S_SPLIT:
                begin
                    if (!e_reg[0])
                    begin
                        e_reg <= {1'b0, e_reg[NUMBER_BITS-1:1]};
                        s_reg <= s_reg + bit_count_t'(1);
                    end
                    else
                    begin
                        mul_x_reg     <= ONE;
                        mul_m_reg     <= w_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_RED;
                    end
                end

                S_RED:
                begin
                    if (mul_done)
                    begin
                        a_reg <= mul_result;
                        if (mul_result == '0)
                        begin
                            comp_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            y_reg         <= ONE;
                            cnt_reg       <= bit_count_t'(NUMBER_BITS);
                            mul_x_reg     <= ONE;
                            mul_m_reg     <= ONE;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_EXP_SQ;
                        end
                    end
                end

                S_EXP_SQ, S_EXP_MUL:
                begin
                    if (mul_done)
                    begin
                        y_reg <= mul_result;
                        if (state_reg == S_EXP_SQ && e_reg[NUMBER_BITS-1])
                        begin
                            mul_x_reg     <= mul_result;
                            mul_m_reg     <= a_reg;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_EXP_MUL;
                        end
                        else if (cnt_reg == bit_count_t'(1))
                        begin
                            k_reg     <= '0;
                            state_reg <= S_CHK;
                        end
                        else
                        begin
                            cnt_reg       <= cnt_reg - bit_count_t'(1);
                            e_reg         <= {e_reg[NUMBER_BITS-2:0], 1'b0};
                            mul_x_reg     <= mul_result;
                            mul_m_reg     <= mul_result;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_EXP_SQ;
                        end
                    end
                end

                S_CHK:
                begin
                    if (k_reg == s_reg || y_reg == ONE || y_reg == nm1_reg)
                    begin
                        comp_reg  <= (y_reg != nm1_reg) && (k_reg != '0);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        mul_x_reg     <= y_reg;
                        mul_m_reg     <= y_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_POST_SQ;
                    end
                end

                S_POST_SQ:
                begin
                    if (mul_done)
                    begin
                        y_reg     <= mul_result;
                        k_reg     <= k_reg + bit_count_t'(1);
                        state_reg <= S_CHK;
                    end
                end

                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg      <= 1'b1;
                        probably_prime_reg <= !(seen_reg || comp_reg);
                        verdict_final_reg  <= fin_reg;
                        seen_reg           <= fin_reg ? 1'b0 : (seen_reg || comp_reg);
                        state_reg          <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign probably_prime = probably_prime_reg;
    assign verdict_final  = verdict_final_reg;

endmodule

>>> rtl/mrr_checker.sv
// ----------------------------------------------------------------------------
// mrr_checker
// Port-level checks for the Miller-Rabin round engine, bound to the top level.
// ----------------------------------------------------------------------------
module mrr_checker
    import mrr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic probably_prime,
    input logic verdict_final
);

    logic [1:0] pending_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // count transfers taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, in_xfer} - {1'b0, out_xfer};
        end
    end

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result shown with no pending transfer");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input ready right after a transfer");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(probably_prime) && $stable(verdict_final))
        else $error("stalled result changed");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two items in flight");

endmodule

bind miller_rabin_round_top mrr_checker u_mrr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .probably_prime (probably_prime),
    .verdict_final  (verdict_final)
);
